// ----- rtl/http_header_line_parser_core_macros.svh -----
// ----------------------------------------------------------------------------
// HTTP header line parser assertion macros
// Short forms for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_LINE_PARSER_CORE_MACROS_SVH
`define HTTP_HEADER_LINE_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HHLP_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define HHLP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/hhlp_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP header line parser package
// Payload types, parser phases, byte codes and role codes.
// ----------------------------------------------------------------------------
package hhlp_pkg;

  localparam int unsigned OffsetWidth = 9;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;

  localparam logic [OffsetWidth-1:0] ValueLimitReset = OffsetWidth'(255);

  localparam logic [1:0] RoleDelim = 2'd0;
  localparam logic [1:0] RoleKey   = 2'd1;
  localparam logic [1:0] RoleValue = 2'd2;
  localparam logic [1:0] RoleAfter = 2'd3;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_KEY      = 4'd1,
    PH_COLON    = 4'd2,
    PH_SPACE    = 4'd3,
    PH_VALUE    = 4'd4,
    PH_CR       = 4'd5,
    PH_LINE_END = 4'd6,
    PH_END_CR   = 4'd7,
    PH_DONE     = 4'd8,
    PH_ERROR    = 4'd9
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [1:0] role;
    logic       line_done;
    logic       headers_done;
    logic       parse_error;
  } out_t;

  typedef struct packed {
    phase_e                 phase;
    logic [OffsetWidth-1:0] value_offset;
  } parse_state_t;

endpackage

// ----- rtl/hhlp_step.sv -----
// ----------------------------------------------------------------------------
// HTTP header line parser step
// Combinational tagging of one byte and the parser state update.
// ----------------------------------------------------------------------------
module hhlp_step (
  input  hhlp_pkg::parse_state_t             state_i,
  input  logic [hhlp_pkg::OffsetWidth-1:0]   value_limit_i,
  input  hhlp_pkg::in_t                      item_i,
  output hhlp_pkg::parse_state_t             state_o,
  output hhlp_pkg::out_t                     result_o
);
  import hhlp_pkg::*;

  phase_e                 phase;
  logic [OffsetWidth-1:0] offset;
  logic [7:0]             b;
  logic                   is_crlf;
  logic                   err;

  assign b       = item_i.data_byte;
  assign is_crlf = (b == CharCr) || (b == CharLf);
  // A restart puts the parser back at line start before this byte is handled.
  assign phase   = item_i.restart ? PH_START : state_i.phase;
  assign offset  = item_i.restart ? '0 : state_i.value_offset;

  always_comb begin
    state_o.phase        = phase;
    state_o.value_offset = offset;
    result_o.byte_out     = b;
    result_o.role         = RoleDelim;
    result_o.line_done    = 1'b0;
    result_o.headers_done = 1'b0;
    err                   = 1'b0;

    unique case (phase)
      PH_START: begin
        if (is_crlf) begin
          result_o.role = RoleDelim;
        end else if (b == CharColon) begin
          err = 1'b1;
        end else begin
          result_o.role = RoleKey;
          state_o.phase = PH_KEY;
        end
      end
      PH_KEY: begin
        if (b == CharColon) begin
          state_o.phase = PH_COLON;
        end else if (is_crlf) begin
          err = 1'b1;
        end else begin
          result_o.role = RoleKey;
        end
      end
      PH_COLON: begin
        if (b == CharSpace) begin
          state_o.phase = PH_SPACE;
        end else begin
          err = 1'b1;
        end
      end
      PH_SPACE: begin
        if (b == CharCr) begin
          err = 1'b1;
        end else begin
          result_o.role        = RoleValue;
          state_o.value_offset = '0;
          state_o.phase        = PH_VALUE;
        end
      end
      PH_VALUE: begin
        // offset + 1 > limit is the same test as offset >= limit.
        if (b == CharCr) begin
          state_o.phase = PH_CR;
        end else if (offset >= value_limit_i) begin
          err = 1'b1;
        end else begin
          state_o.value_offset = offset + OffsetWidth'(1);
          result_o.role        = RoleValue;
        end
      end
      PH_CR: begin
        if (b == CharLf) begin
          result_o.line_done = 1'b1;
          state_o.phase      = PH_LINE_END;
        end else begin
          err = 1'b1;
        end
      end
      PH_LINE_END: begin
        if (b == CharCr) begin
          state_o.phase = PH_END_CR;
        end else if ((b == CharLf) || (b == CharColon)) begin
          err = 1'b1;
        end else begin
          result_o.role = RoleKey;
          state_o.phase = PH_KEY;
        end
      end
      PH_END_CR: begin
        if (b == CharLf) begin
          result_o.headers_done = 1'b1;
          state_o.phase         = PH_DONE;
        end else begin
          err = 1'b1;
        end
      end
      PH_DONE: begin
        result_o.role = RoleAfter;
      end
      default: begin
        // The error phase, and any code that is not a phase, stays in error.
        state_o.phase = PH_ERROR;
        result_o.role = RoleAfter;
      end
    endcase

    if (err) begin
      result_o.role = RoleDelim;
      state_o.phase = PH_ERROR;
    end
    result_o.parse_error = err;
  end

endmodule

// ----- rtl/http_header_line_parser_core.sv -----
// ----------------------------------------------------------------------------
// HTTP header line parser core
// Tags each byte of an HTTP header section as delimiter, key, value or after byte.
// ----------------------------------------------------------------------------
// The core takes the bytes that follow a request line, one byte per input
// transfer, and returns exactly one result transfer per byte, in order. It
// sustains one byte per clock cycle while the consumer keeps up. A byte is
// captured in the input register, where the phase update runs on it, and its
// tag is then captured in the result register when that register is empty or
// is being drained. Both sides are decoupled by these registers, so a new
// byte is taken while a finished result still waits for the consumer; the
// input stalls only when both registers hold a byte and the consumer is not
// ready. The value length limit is written over the configuration channel,
// which is always ready; write it only while no byte is in flight. Error and
// end of section are sticky until a byte arrives with its restart bit set.
// ----------------------------------------------------------------------------
module http_header_line_parser_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  hhlp_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output hhlp_pkg::out_t                   out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hhlp_pkg::OffsetWidth-1:0] cfg_data_i
);
  import hhlp_pkg::*;

  // Input register stage.
  logic         s1_valid_q;
  in_t          s1_data_q;
  // Result register stage.
  logic         out_valid_q;
  out_t         out_data_q;
  // Parser state and configuration.
  parse_state_t state_q, state_d;
  out_t         result_d;
  logic [OffsetWidth-1:0] value_limit_q;

  logic s2_ready;
  logic advance;
  logic in_xfer;

  // The result register frees up when it is empty or is being drained.
  assign s2_ready   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  hhlp_step u_step (
    .state_i       (state_q),
    .value_limit_i (value_limit_q),
    .item_i        (s1_data_q),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  // Control state: valid flags, parser state and the limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q.phase <= PH_START;
      state_q.value_offset <= '0;
      value_limit_q <= ValueLimitReset;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
      // The parser state moves only when its byte moves into the result stage.
      if (advance) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        value_limit_q <= cfg_data_i;
      end
    end
  end

  // Payload registers need no reset; their valid flags qualify them.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result_d;
    end
  end

endmodule

// ----- rtl/hhlp_checker.sv -----
// ----------------------------------------------------------------------------
// HTTP header line parser checker
// Port-level checks on the parser core, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "http_header_line_parser_core_macros.svh"

module hhlp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input hhlp_pkg::out_t out_data_o
);
  import hhlp_pkg::*;

  // A stalled result stays offered and unchanged.
  `HHLP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // The input side only stalls when a full result stage is itself stalled.
  `HHLP_ASSERT_NOW(a_in_backpressure, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // A completed line or section is always marked on a clean LF delimiter.
  `HHLP_ASSERT_NOW(a_done_on_lf, clk_i, rst_ni, out_valid_o && (out_data_o.line_done || out_data_o.headers_done), (out_data_o.byte_out == CharLf) && (out_data_o.role == RoleDelim) && !out_data_o.parse_error)

  // The byte that raises an error is tagged as a delimiter with no done flag.
  `HHLP_ASSERT_NOW(a_error_role, clk_i, rst_ni, out_valid_o && out_data_o.parse_error, (out_data_o.role == RoleDelim) && !out_data_o.line_done && !out_data_o.headers_done)

endmodule

bind http_header_line_parser_core hhlp_checker u_hhlp_checker (.*);

// ----- tb/http_header_line_parser_core_tb.sv -----
// ----------------------------------------------------------------------------
// HTTP header line parser core testbench
// Streams header sections, directed and random, through the parser under
// bursty input and a stalling consumer, and checks every tagged byte against
// an in-bench prediction of the parser phase machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_header_line_parser_core_tb;

  import hhlp_pkg::*;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  // Block inputs start at known values so that nothing is undriven before
  // the first clock edge.
  logic                   in_valid   = 1'b0;
  in_t                    in_data    = '0;
  logic                   out_ready  = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic [OffsetWidth-1:0] cfg_data   = '0;

  logic                   in_ready_o;
  logic                   out_valid_o;
  out_t                   out_data_o;
  logic                   cfg_ready_o;

  http_header_line_parser_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  // Bytes waiting to be offered, and tags predicted for accepted bytes.
  in_t  pending_bytes[$];
  out_t expected_tags[$];
  int   fail_count = 0;

  // Shadow copy of the parser state and of its value length limit.
  phase_e                 shadow_phase  = PH_START;
  logic [OffsetWidth-1:0] shadow_offset = '0;
  logic [OffsetWidth-1:0] shadow_limit  = ValueLimitReset;

  // --------------------------------------------------------------------------
  // Tag prediction. Advances the shadow phase machine by one byte and returns
  // the tag that the parser must produce for it.
  // --------------------------------------------------------------------------
  function automatic out_t tag_byte(in_t item);
    out_t       tag;
    logic       bad;
    logic [7:0] b;
    b   = item.data_byte;
    tag = '0;
    tag.byte_out = b;
    tag.role     = RoleDelim;
    bad = 1'b0;
    if (item.restart) begin
      shadow_phase  = PH_START;
      shadow_offset = '0;
    end
    case (shadow_phase)
      PH_START: begin
        // CR and LF ahead of the first key are skipped silently.
        if (b != CharCr && b != CharLf) begin
          if (b == CharColon) begin
            bad = 1'b1;
          end else begin
            tag.role     = RoleKey;
            shadow_phase = PH_KEY;
          end
        end
      end
      PH_KEY: begin
        if (b == CharColon) begin
          shadow_phase = PH_COLON;
        end else if (b == CharCr || b == CharLf) begin
          bad = 1'b1;
        end else begin
          tag.role = RoleKey;
        end
      end
      PH_COLON: begin
        if (b == CharSpace) shadow_phase = PH_SPACE;
        else bad = 1'b1;
      end
      PH_SPACE: begin
        // A value needs at least one byte.
        if (b == CharCr) begin
          bad = 1'b1;
        end else begin
          tag.role      = RoleValue;
          shadow_offset = '0;
          shadow_phase  = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (b == CharCr) begin
          shadow_phase = PH_CR;
        end else if ({1'b0, shadow_offset} + 10'd1 > {1'b0, shadow_limit}) begin
          bad = 1'b1;
        end else begin
          shadow_offset = shadow_offset + 1'b1;
          tag.role      = RoleValue;
        end
      end
      PH_CR: begin
        if (b == CharLf) begin
          tag.line_done = 1'b1;
          shadow_phase  = PH_LINE_END;
        end else begin
          bad = 1'b1;
        end
      end
      PH_LINE_END: begin
        if (b == CharCr) begin
          shadow_phase = PH_END_CR;
        end else if (b == CharLf || b == CharColon) begin
          bad = 1'b1;
        end else begin
          tag.role     = RoleKey;
          shadow_phase = PH_KEY;
        end
      end
      PH_END_CR: begin
        if (b == CharLf) begin
          tag.headers_done = 1'b1;
          shadow_phase     = PH_DONE;
        end else begin
          bad = 1'b1;
        end
      end
      PH_DONE: tag.role = RoleAfter;
      default: begin
        shadow_phase = PH_ERROR;
        tag.role     = RoleAfter;
      end
    endcase
    if (bad) begin
      tag.role        = RoleDelim;
      tag.parse_error = 1'b1;
      shadow_phase    = PH_ERROR;
    end
    return tag;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver. A byte is handed over in bursts of random length separated
  // by random gaps; some gaps are zero so that long back-to-back stretches
  // occur. Once valid is raised it is held until the transfer completes.
  // --------------------------------------------------------------------------
  int   burst_left = 0;
  int   gap_left   = 0;
  logic drv_valid;
  in_t  drv_data;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left =  0;
      gap_left   =  0;
    end else begin
      drv_valid = in_valid;
      drv_data  = in_data;
      if (in_valid && in_ready_o) begin
        // The prediction is made at the transfer, with the limit in force.
        expected_tags.push_back(tag_byte(in_data));
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bytes.size() > 0) begin
          drv_data  = pending_bytes.pop_front();
          drv_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid <= drv_valid;
      in_data  <= drv_data;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and consumer. The consumer switches at random between
  // three stall modes; once, after enough results, it holds off for a long
  // stretch so that both internal registers fill and the input stalls.
  // --------------------------------------------------------------------------
  int   results_seen = 0;
  int   hold_left    = 0;
  bit   hold_done    = 1'b0;
  int   stall_mode   = 0;
  int   mode_left    = 0;
  logic rcv_ready;
  out_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (expected_tags.size() == 0) begin
          $error("unexpected result transfer: byte_out %0h", out_data_o.byte_out);
          fail_count++;
        end else begin
          want = expected_tags.pop_front();
          if (out_data_o.byte_out !== want.byte_out) begin
            $error("byte_out: expected %0h, actual %0h", want.byte_out, out_data_o.byte_out);
            fail_count++;
          end
          if (out_data_o.role !== want.role) begin
            $error("role: expected %0d, actual %0d", want.role, out_data_o.role);
            fail_count++;
          end
          if (out_data_o.line_done !== want.line_done) begin
            $error("line_done: expected %0d, actual %0d",
                   want.line_done, out_data_o.line_done);
            fail_count++;
          end
          if (out_data_o.headers_done !== want.headers_done) begin
            $error("headers_done: expected %0d, actual %0d",
                   want.headers_done, out_data_o.headers_done);
            fail_count++;
          end
          if (out_data_o.parse_error !== want.parse_error) begin
            $error("parse_error: expected %0d, actual %0d",
                   want.parse_error, out_data_o.parse_error);
            fail_count++;
          end
        end
      end

      if (hold_left > 0) begin
        hold_left--;
        rcv_ready = 1'b0;
      end else if (!hold_done && results_seen >= 60) begin
        hold_done = 1'b1;
        hold_left = 80;
        rcv_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(10, 60);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       rcv_ready = 1'b1;
          1:       rcv_ready = ($urandom_range(0, 3) != 0);
          default: rcv_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ready <= rcv_ready;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_byte(logic [7:0] b, logic rs);
    in_t item;
    item.data_byte = b;
    item.restart   = rs;
    pending_bytes.push_back(item);
  endtask

  task automatic push_text(string s, bit restart_first);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], restart_first && i == 0);
  endtask

  function automatic logic [7:0] rand_key_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CharCr || b == CharLf || b == CharColon);
    return b;
  endfunction

  function automatic logic [7:0] rand_value_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CharCr);
    return b;
  endfunction

  // One header section with random content, sometimes with one byte broken.
  task automatic push_section(int unsigned lim);
    logic [7:0]  sec[$];
    int unsigned small_max;
    int unsigned vlen;
    int unsigned pick;
    int unsigned pos;
    small_max = (lim + 1 < 10) ? lim + 1 : 10;
    repeat ($urandom_range(0, 2)) sec.push_back($urandom_range(0, 1) ? CharCr : CharLf);
    repeat ($urandom_range(0, 4)) begin
      repeat ($urandom_range(1, 6)) sec.push_back(rand_key_char());
      sec.push_back(CharColon);
      sec.push_back(CharSpace);
      pick = $urandom_range(0, 9);
      if (pick < 7 || lim > 40) vlen = $urandom_range(1, small_max);
      else if (pick < 9) vlen = lim + 1;
      else vlen = lim + 2;
      repeat (vlen) sec.push_back(rand_value_char());
      sec.push_back(CharCr);
      sec.push_back(CharLf);
    end
    sec.push_back(CharCr);
    sec.push_back(CharLf);
    repeat ($urandom_range(0, 3)) sec.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 5) == 0) begin
      pos = $urandom_range(0, sec.size() - 1);
      case ($urandom_range(0, 4))
        0:       sec[pos] = CharCr;
        1:       sec[pos] = CharLf;
        2:       sec[pos] = CharColon;
        3:       sec[pos] = CharSpace;
        default: sec[pos] = 8'($urandom_range(0, 255));
      endcase
    end
    foreach (sec[i]) push_byte(sec[i], i == 0);
  endtask

  // Random phase: mostly well-formed sections, some raw noise.
  task automatic push_random_phase(int unsigned lim, int target);
    int before_size;
    int count;
    count = 0;
    while (count < target) begin
      before_size = pending_bytes.size();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(3, 12))
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      end else begin
        push_section(lim);
      end
      count += pending_bytes.size() - before_size;
    end
  endtask

  // A single header line with a value of the given length, then end of section.
  task automatic push_long_line(int vlen);
    push_text("L: ", 1'b1);
    repeat (vlen) push_byte(rand_value_char(), 1'b0);
    push_text("\015\012\015\012", 1'b0);
  endtask

  // Waits until every offered byte has its result back; the extra cycles
  // cover the two-stage pipeline before the limit is changed.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_tags.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_value_limit(logic [OffsetWidth-1:0] lim);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid    <= 1'b0;
    shadow_limit =  lim;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence. Each phase is followed by a full drain, which also makes
  // the sender pause until every expected result has come back.
  // --------------------------------------------------------------------------
  logic [OffsetWidth-1:0] mid_limit;

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset limit.
    // Leading CR LF, one complete line, end of section, then a byte after done.
    push_text("\015\012H: v\015\012\015\012", 1'b1);
    push_byte(8'hFF, 1'b0);
    // Empty key, then a byte after the error.
    push_text(":", 1'b1);
    push_byte(8'h00, 1'b0);
    // CR inside a key.
    push_text("K\015", 1'b1);
    // Wrong byte after the colon.
    push_text("K:x", 1'b1);
    // Empty value.
    push_text("K: \015", 1'b1);
    wait_drained();

    // Tightest limit in this test: two value bytes at most.
    write_value_limit(OffsetWidth'(1));
    push_random_phase(1, 90);
    wait_drained();

    // A wider limit: one value right at the edge, one just past it.
    write_value_limit(OffsetWidth'(48));
    push_long_line(49);
    push_long_line(50);
    push_random_phase(48, 50);
    wait_drained();

    mid_limit = OffsetWidth'($urandom_range(2, 40));
    write_value_limit(mid_limit);
    push_random_phase(mid_limit, 90);
    wait_drained();

    write_value_limit(ValueLimitReset);
    push_random_phase(255, 50);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (expected_tags.size() != 0) begin
      $error("%0d expected results never arrived", expected_tags.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("http_header_line_parser_core_tb: PASS");
    end else begin
      $display("http_header_line_parser_core_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("http_header_line_parser_core_tb: FAIL");
    $finish;
  end

endmodule
